@@ design/assert_macros.svh @@
// assertion macros shared by the uplink supervisor rtl
// no dependencies; every macro is empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

@@ design/uplrs_pkg.sv @@
// types, codes and reset values of the uplink reconnect supervisor
// no dependencies; used by every module of the block
package uplrs_pkg;

  // item operation codes
  typedef enum logic [2:0] {
    OP_POLL      = 3'd0,
    OP_SOCK_UP   = 3'd1,
    OP_SOCK_DOWN = 3'd2,
    OP_READY     = 3'd3,
    OP_BEGIN     = 3'd4,
    OP_SEND_OK   = 3'd5,
    OP_SEND_FAIL = 3'd6,
    OP_SKIP      = 3'd7
  } op_e;

  // capture command codes
  typedef enum logic [1:0] {
    CAP_NONE = 2'd0,
    CAP_GO   = 2'd1,
    CAP_STOP = 2'd2
  } cap_e;

  // link state, one-hot
  typedef enum logic [2:0] {
    LINK_DOWN    = 3'b001,
    LINK_READY   = 3'b010,
    LINK_SENDING = 3'b100
  } link_e;

  // status codes seen on the result
  localparam logic [1:0] STATUS_DOWN    = 2'd0;
  localparam logic [1:0] STATUS_READY   = 2'd1;
  localparam logic [1:0] STATUS_SENDING = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_INIT_BACKOFF = 2'd0;
  localparam logic [1:0] REG_MAX_BACKOFF  = 2'd1;
  localparam logic [1:0] REG_CONN_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_READY_WAIT  = 2'd3;

  localparam int unsigned RegW     = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned BackoffW = 17;

  // reset values
  localparam logic [RegW-1:0] InitBackoffRst = 16'd2000;
  localparam logic [RegW-1:0] MaxBackoffRst  = 16'd30000;
  localparam logic [RegW-1:0] ConnTimeoutRst = 16'd10000;
  localparam logic [RegW-1:0] ReadyWaitRst   = 16'd3000;

  typedef struct packed {
    logic [RegW-1:0] init_backoff;
    logic [RegW-1:0] max_backoff;
    logic [RegW-1:0] conn_timeout;
    logic [RegW-1:0] ready_wait;
  } cfg_t;

  typedef struct packed {
    cap_e       capture_cmd;
    logic [1:0] link_status;
    logic       send_granted;
    logic       drop_socket;
    logic       start_connect;
  } res_t;

  // link state to status code
  function automatic logic [1:0] link_code(link_e st);
    logic [1:0] code;
    unique case (st)
      LINK_READY:   code = STATUS_READY;
      LINK_SENDING: code = STATUS_SENDING;
      default:      code = STATUS_DOWN;
    endcase
    return code;
  endfunction

endpackage

@@ design/uplrs_cfg_regs.sv @@
// configuration registers of the uplink supervisor
// depends on uplrs_pkg
module uplrs_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [uplrs_pkg::RegW-1:0]  cfg_wdata_i,
  output uplrs_pkg::cfg_t             cfg_o
);

  uplrs_pkg::cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uplrs_pkg::REG_INIT_BACKOFF: cfg_d.init_backoff = cfg_wdata_i;
        uplrs_pkg::REG_MAX_BACKOFF:  cfg_d.max_backoff  = cfg_wdata_i;
        uplrs_pkg::REG_CONN_TIMEOUT: cfg_d.conn_timeout = cfg_wdata_i;
        uplrs_pkg::REG_READY_WAIT:   cfg_d.ready_wait   = cfg_wdata_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_backoff <= uplrs_pkg::InitBackoffRst;
      cfg_q.max_backoff  <= uplrs_pkg::MaxBackoffRst;
      cfg_q.conn_timeout <= uplrs_pkg::ConnTimeoutRst;
      cfg_q.ready_wait   <= uplrs_pkg::ReadyWaitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/uplrs_core.sv @@
// link state, backoff and timestamp registers with the per-item decision logic
// depends on uplrs_pkg and assert_macros.svh
`include "assert_macros.svh"
module uplrs_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  uplrs_pkg::op_e               op_i,
  input  logic [uplrs_pkg::TimeW-1:0]  now_i,
  input  logic                         link_up_i,
  input  logic                         enabled_i,
  input  logic                         target_i,
  input  logic                         connected_i,
  input  uplrs_pkg::cfg_t              cfg_i,
  output uplrs_pkg::res_t              res_o
);

  localparam int unsigned TW = uplrs_pkg::TimeW;
  localparam int unsigned BW = uplrs_pkg::BackoffW;

  uplrs_pkg::link_e link_q, link_d;
  logic [BW-1:0]    backoff_q, backoff_d;
  logic [TW-1:0]    conn_time_q, conn_time_d;
  logic [TW-1:0]    attempt_q, attempt_d;
  logic [TW-1:0]    retry_q, retry_d;

  uplrs_pkg::cap_e  cap;
  logic             granted, drop, start;

  logic [TW-1:0]    conn_age, attempt_age, retry_age;
  logic             wait_over, attempt_over, retry_early;
  logic [BW-1:0]    max_ext, backoff_dbl;

  // elapsed times, modulo 2^32
  assign conn_age     = now_i - conn_time_q;
  assign attempt_age  = now_i - attempt_q;
  assign retry_age    = now_i - retry_q;
  assign wait_over    = conn_age > {{(TW-uplrs_pkg::RegW){1'b0}}, cfg_i.ready_wait};
  assign attempt_over = attempt_age > {{(TW-uplrs_pkg::RegW){1'b0}}, cfg_i.conn_timeout};
  assign retry_early  = retry_age < {{(TW-BW){1'b0}}, backoff_q};

  // doubling only happens below the 16-bit ceiling, so the shift cannot overflow
  assign max_ext     = {1'b0, cfg_i.max_backoff};
  assign backoff_dbl = {backoff_q[BW-2:0], 1'b0};

  // next state and result of one item
  always_comb begin
    link_d      = link_q;
    backoff_d   = backoff_q;
    conn_time_d = conn_time_q;
    attempt_d   = attempt_q;
    retry_d     = retry_q;
    cap         = uplrs_pkg::CAP_NONE;
    granted     = 1'b0;
    drop        = 1'b0;
    start       = 1'b0;
    unique case (op_i)
      uplrs_pkg::OP_POLL: begin
        if (enabled_i) begin
          if (!link_up_i) begin
            if (link_q != uplrs_pkg::LINK_DOWN) begin
              link_d = uplrs_pkg::LINK_DOWN;
              cap    = uplrs_pkg::CAP_STOP;
            end
          end else if (target_i) begin
            if (connected_i) begin
              if (link_q == uplrs_pkg::LINK_READY) begin
                attempt_d = '0;
              end else if (conn_time_q != '0 && wait_over) begin
                // no ready frame in time: force ready
                backoff_d = {1'b0, cfg_i.init_backoff};
                attempt_d = '0;
                link_d    = uplrs_pkg::LINK_READY;
                cap       = uplrs_pkg::CAP_GO;
              end
            end else begin
              if (link_q != uplrs_pkg::LINK_DOWN) begin
                link_d = uplrs_pkg::LINK_DOWN;
                cap    = uplrs_pkg::CAP_STOP;
              end
              if (attempt_q != '0) begin
                // abandon a stale attempt and grow the backoff
                if (attempt_over) begin
                  drop        = 1'b1;
                  link_d      = uplrs_pkg::LINK_DOWN;
                  conn_time_d = '0;
                  attempt_d   = '0;
                  cap         = uplrs_pkg::CAP_STOP;
                  if (backoff_q < max_ext) begin
                    backoff_d = (backoff_dbl > max_ext) ? max_ext : backoff_dbl;
                  end
                end
              end else if (retry_q == '0 || !retry_early) begin
                // new connection attempt
                retry_d     = now_i;
                attempt_d   = now_i;
                link_d      = uplrs_pkg::LINK_DOWN;
                conn_time_d = '0;
                drop        = 1'b1;
                start       = 1'b1;
              end
            end
          end
        end
      end
      uplrs_pkg::OP_SOCK_UP: begin
        link_d      = uplrs_pkg::LINK_DOWN;
        conn_time_d = now_i;
      end
      uplrs_pkg::OP_SOCK_DOWN, uplrs_pkg::OP_SEND_FAIL: begin
        link_d      = uplrs_pkg::LINK_DOWN;
        conn_time_d = '0;
        attempt_d   = '0;
        cap         = uplrs_pkg::CAP_STOP;
      end
      uplrs_pkg::OP_READY: begin
        backoff_d = {1'b0, cfg_i.init_backoff};
        attempt_d = '0;
        link_d    = uplrs_pkg::LINK_READY;
        cap       = uplrs_pkg::CAP_GO;
      end
      uplrs_pkg::OP_BEGIN: begin
        if (link_q == uplrs_pkg::LINK_READY) begin
          link_d  = uplrs_pkg::LINK_SENDING;
          granted = 1'b1;
        end
      end
      uplrs_pkg::OP_SEND_OK: begin
        if (link_q == uplrs_pkg::LINK_SENDING) begin
          link_d = uplrs_pkg::LINK_READY;
        end
        cap = uplrs_pkg::CAP_GO;
      end
      uplrs_pkg::OP_SKIP: begin
        if (link_q != uplrs_pkg::LINK_DOWN) begin
          link_d = uplrs_pkg::LINK_READY;
          cap    = uplrs_pkg::CAP_GO;
        end
      end
      default: begin
        link_d = link_q;
      end
    endcase
  end

  // state registers, updated on every accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q      <= uplrs_pkg::LINK_DOWN;
      backoff_q   <= {1'b0, uplrs_pkg::InitBackoffRst};
      conn_time_q <= '0;
      attempt_q   <= '0;
      retry_q     <= '0;
    end else if (acc_i) begin
      link_q      <= link_d;
      backoff_q   <= backoff_d;
      conn_time_q <= conn_time_d;
      attempt_q   <= attempt_d;
      retry_q     <= retry_d;
    end
  end

  // result of the item, status after the update
  always_comb begin
    res_o.capture_cmd   = cap;
    res_o.link_status   = uplrs_pkg::link_code(link_d);
    res_o.send_granted  = granted;
    res_o.drop_socket   = drop;
    res_o.start_connect = start;
  end

  `ASSERT_PROP(a_grant_sends, clk_i, rst_ni,
    acc_i && res_o.send_granted |=> link_q == uplrs_pkg::LINK_SENDING,
    "granted send did not enter sending")
  `ASSERT_PROP(a_connect_stamps, clk_i, rst_ni,
    acc_i && res_o.start_connect |=> attempt_q == $past(now_i) && retry_q == $past(now_i),
    "connect attempt did not record its time")
  `ASSERT_PROP(a_sock_down_clears, clk_i, rst_ni,
    acc_i && op_i == uplrs_pkg::OP_SOCK_DOWN |=>
      link_q == uplrs_pkg::LINK_DOWN && conn_time_q == '0 && attempt_q == '0,
    "socket down left state behind")

endmodule

@@ design/uplrs_out_skid.sv @@
// two-entry result buffer: output register plus skid register
// depends on uplrs_pkg and assert_macros.svh
`include "assert_macros.svh"
module uplrs_out_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  uplrs_pkg::res_t  in_res_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output uplrs_pkg::res_t  out_res_o
);

  logic            out_valid_q, skid_valid_q;
  uplrs_pkg::res_t out_res_q, skid_res_q;
  logic            in_acc, out_take;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_res_q <= skid_res_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_res_q <= in_res_i;
      end else begin
        out_res_q <= in_res_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  `ASSERT_NEVER(a_skid_needs_out, clk_i, rst_ni,
    skid_valid_q && !out_valid_q,
    "skid entry held with empty output register")
  `ASSERT_PROP(a_fill_skid, clk_i, rst_ni,
    in_acc && out_valid_q && out_stall_i |=> skid_valid_q,
    "transfer behind a stalled result was not kept")
  `ASSERT_PROP(a_drain_empty, clk_i, rst_ni,
    out_take && !skid_valid_q && !in_acc |=> !out_valid_q,
    "output stayed valid after its only result was taken")

endmodule

@@ design/uplink_reconnect_supervisor.sv @@
// top level of the uplink reconnect supervisor
// depends on uplrs_pkg, uplrs_cfg_regs, uplrs_core and uplrs_out_skid

// One item is accepted per clock cycle while in_stall_o is low and gives exactly one
// result, registered in the output register or, while an older result waits, in the
// skid register; the whole decision for an item (a few 32-bit time differences and
// compares, the backoff doubling) is one combinational step from the input ports
// into the state and result registers, so consecutive items see each other's state
// without bubbles. A two-entry result buffer lets the input keep flowing while one
// result waits; in_stall_o rises only once both entries hold results. Configuration
// writes take effect on the next cycle and belong in idle periods.
module uplink_reconnect_supervisor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [uplrs_pkg::RegW-1:0]   cfg_wdata_i,
  // item input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   op_i,
  input  logic [uplrs_pkg::TimeW-1:0]  now_ms_i,
  input  logic                         link_up_i,
  input  logic                         uplink_enabled_i,
  input  logic                         target_configured_i,
  input  logic                         socket_connected_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   capture_cmd_o,
  output logic [1:0]                   link_status_o,
  output logic                         send_granted_o,
  output logic                         drop_socket_o,
  output logic                         start_connect_o
);

  uplrs_pkg::cfg_t cfg;
  uplrs_pkg::res_t core_res, out_res;
  logic            in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  uplrs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  uplrs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .op_i        (uplrs_pkg::op_e'(op_i)),
    .now_i       (now_ms_i),
    .link_up_i   (link_up_i),
    .enabled_i   (uplink_enabled_i),
    .target_i    (target_configured_i),
    .connected_i (socket_connected_i),
    .cfg_i       (cfg),
    .res_o       (core_res)
  );

  uplrs_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_res_i    (core_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  // result fields
  assign capture_cmd_o   = out_res.capture_cmd;
  assign link_status_o   = out_res.link_status;
  assign send_granted_o  = out_res.send_granted;
  assign drop_socket_o   = out_res.drop_socket;
  assign start_connect_o = out_res.start_connect;

endmodule
